// ===== sv/aging_address_ring_table_macros.svh =====
// Assertion macros shared by the checker of the aging address ring table.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef AGING_ADDRESS_RING_TABLE_MACROS_SVH
`define AGING_ADDRESS_RING_TABLE_MACROS_SVH

// antecedent holds -> consequent in the same cycle
`define AART_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent in the next cycle
`define AART_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/aart_pkg.sv =====
// Types and constants of the aging address ring table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package aart_pkg;

  localparam int ADDR_W     = 48;
  localparam int TIME_W     = 32;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 7;
  localparam int IN_DATA_W  = 80;   // address, now
  localparam int OUT_DATA_W = 64;   // status, near, removed, removed_address, occupancy, pad
  localparam int OUT_USED_W = STATUS_W + 2 + ADDR_W + OCC_W;

  localparam logic [TIME_W-1:0] MAX_AGE_RST = 32'd1200;
  localparam logic [TIME_W-1:0] MIN_AGE_RST = 32'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_EXPIRE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    REG_MAX_AGE = 1'b0,
    REG_MIN_AGE = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic shift;   // take the neighbour's entry
    logic load;    // take the new entry
  } cell_ctrl_t;

endpackage

// ===== sv/aart_cell.sv =====
// One storage cell of the ring: an address and its insertion time.
// Depends on aart_pkg for widths and the control struct.
`timescale 1ns / 1ps

module aart_cell (
  input  logic                      clk,
  input  aart_pkg::cell_ctrl_t      ctrl,
  input  logic [aart_pkg::ADDR_W-1:0] shift_addr,
  input  logic [aart_pkg::TIME_W-1:0] shift_time,
  input  logic [aart_pkg::ADDR_W-1:0] load_addr,
  input  logic [aart_pkg::TIME_W-1:0] load_time,
  output logic [aart_pkg::ADDR_W-1:0] addr_q,
  output logic [aart_pkg::TIME_W-1:0] time_q
);

  logic [aart_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [aart_pkg::TIME_W-1:0] time_r, time_nxt;

  always_comb begin
    addr_nxt = addr_r;
    time_nxt = time_r;
    if (ctrl.load) begin
      addr_nxt = load_addr;
      time_nxt = load_time;
    end else if (ctrl.shift) begin
      addr_nxt = shift_addr;
      time_nxt = shift_time;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    time_r <= time_nxt;
  end

  assign addr_q = addr_r;
  assign time_q = time_r;

endmodule

// ===== sv/aging_address_ring_table.sv =====
// Top level of the aging address ring table: control sequencer and the cell row.
// Depends on aart_pkg and aart_cell.
//
//  channel | direction | handshake          | payload
//  in      | slave     | in_tvalid/tready   | tuser: command; tdata: address, now
//  out     | master    | out_tvalid/tready  | tdata: status, near, removed, addr, occupancy
//  cfg     | write     | cfg_we             | cfg_index, cfg_wdata
//
// Add, expire and unused commands go from IDLE straight to FINISH, which writes the result register.
// A query first passes through SEARCH: the cell row rotates one full turn past
// the single head comparator, which checks one entry per cycle.
// Oldest entry always sits in cell 0; a removing expire shifts the row by one.
// Synchronous active-low reset clears control state; cells are not cleared.
// A new request is taken once the previous result sits in the output register.
`timescale 1ns / 1ps

module aging_address_ring_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [aart_pkg::IN_DATA_W-1:0]      in_tdata,   // address[47:0], now[79:48]
  input  logic [aart_pkg::CMD_W-1:0]          in_tuser,   // command[1:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status[1:0], near[2], removed[3], removed_address[51:4], occupancy[58:52], zero pad
  output logic [aart_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [aart_pkg::TIME_W-1:0]         cfg_wdata
);

  localparam int KW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int AW    = aart_pkg::ADDR_W;
  localparam int TW    = aart_pkg::TIME_W;

  aart_pkg::state_t state_r, state_nxt;
  aart_pkg::cmd_t   cmd_r;
  logic [AW-1:0]    addr_r;
  logic [TW-1:0]    now_r;
  logic [KW-1:0]    k_r, k_nxt;
  logic             near_r, near_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TW-1:0]    max_age_r, min_age_r;
  logic             out_valid_r, out_valid_nxt;
  logic [aart_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [AW-1:0] cell_addr [TABLE_DEPTH];
  logic [TW-1:0] cell_time [TABLE_DEPTH];
  aart_pkg::cell_ctrl_t cell_ctrl [TABLE_DEPTH];

  logic             accept, out_free, shift_all, load_en;
  logic [TW-1:0]    head_age;
  logic             hit, old_enough;
  logic [CNT_W+aart_pkg::OCC_W-1:0] count_ext;
  aart_pkg::status_t status;
  logic             removed;
  logic [AW-1:0]    removed_addr;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      aart_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[gi]),
        .shift_addr (cell_addr[(gi + 1) % TABLE_DEPTH]),
        .shift_time (cell_time[(gi + 1) % TABLE_DEPTH]),
        .load_addr  (addr_r),
        .load_time  (now_r),
        .addr_q     (cell_addr[gi]),
        .time_q     (cell_time[gi])
      );
      always_comb begin
        cell_ctrl[gi].shift = shift_all;
        cell_ctrl[gi].load  = load_en && (count_r == CNT_W'(gi));
      end
    end
  endgenerate

  assign in_tready = (state_r == aart_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aart_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (aart_pkg::cmd_t'(in_tuser) == aart_pkg::CMD_QUERY) ?
                      aart_pkg::ST_SEARCH : aart_pkg::ST_FINISH;
        end
      end
      aart_pkg::ST_SEARCH: begin
        if (k_r == KW'(TABLE_DEPTH - 1)) state_nxt = aart_pkg::ST_FINISH;
      end
      aart_pkg::ST_FINISH: begin
        if (out_free) state_nxt = aart_pkg::ST_IDLE;
      end
      default: state_nxt = aart_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_age   = now_r - cell_time[0];
    hit        = (cell_addr[0] == addr_r) && (head_age > min_age_r) &&
                 (head_age < max_age_r) && (CNT_W'(k_r) < count_r);
    old_enough = head_age > max_age_r;

    shift_all     = 1'b0;
    load_en       = 1'b0;
    k_nxt         = k_r;
    near_nxt      = near_r;
    count_nxt     = count_r;
    status        = aart_pkg::STS_DONE;
    removed       = 1'b0;
    removed_addr  = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      aart_pkg::ST_IDLE: begin
        k_nxt    = '0;
        near_nxt = 1'b0;
      end
      aart_pkg::ST_SEARCH: begin
        shift_all = 1'b1;
        k_nxt     = k_r + KW'(1);
        if (hit) near_nxt = 1'b1;
      end
      aart_pkg::ST_FINISH: begin
        if (out_free) begin
          case (cmd_r)
            aart_pkg::CMD_ADD: begin
              if (count_r >= CNT_W'(TABLE_DEPTH)) begin
                status = aart_pkg::STS_FULL;
              end else begin
                load_en   = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            aart_pkg::CMD_EXPIRE: begin
              if (count_r == '0) begin
                status = aart_pkg::STS_EMPTY;
              end else if (old_enough) begin
                shift_all    = 1'b1;
                removed      = 1'b1;
                removed_addr = cell_addr[0];
                count_nxt    = count_r - CNT_W'(1);
              end
            end
            default: ;
          endcase
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    count_ext = {{aart_pkg::OCC_W{1'b0}}, count_nxt};
    if (state_r == aart_pkg::ST_FINISH && out_free) begin
      out_data_nxt = {{(aart_pkg::OUT_DATA_W - aart_pkg::OUT_USED_W){1'b0}},
                      count_ext[aart_pkg::OCC_W-1:0], removed_addr, removed,
                      (cmd_r == aart_pkg::CMD_QUERY) && near_r, status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aart_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      max_age_r   <= aart_pkg::MAX_AGE_RST;
      min_age_r   <= aart_pkg::MIN_AGE_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (aart_pkg::reg_idx_t'(cfg_index))
          aart_pkg::REG_MAX_AGE: max_age_r <= cfg_wdata;
          aart_pkg::REG_MIN_AGE: min_age_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    near_r     <= near_nxt;
    out_data_r <= out_data_nxt;
    if (accept) begin
      cmd_r  <= aart_pkg::cmd_t'(in_tuser);
      addr_r <= in_tdata[AW-1:0];
      now_r  <= in_tdata[AW+TW-1:AW];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/aart_checker.sv =====
// Port-level checker of the aging address ring table, bound to the top level.
// Depends on aart_pkg and aging_address_ring_table_macros.svh.
`timescale 1ns / 1ps
`include "aging_address_ring_table_macros.svh"

module aart_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [aart_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [aart_pkg::STATUS_W-1:0] status;
  logic                          near;
  logic                          removed;
  logic [aart_pkg::OCC_W-1:0]    occ;
  logic [31:0]                   depth_w;

  assign status  = out_tdata[1:0];
  assign near    = out_tdata[2];
  assign removed = out_tdata[3];
  assign occ     = out_tdata[58:52];
  assign depth_w = 32'(TABLE_DEPTH);

  `AART_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "result changed while stalled")

  `AART_ASSERT_SAME(a_full_occ, out_tvalid && status == aart_pkg::STS_FULL,
    occ == depth_w[aart_pkg::OCC_W-1:0], "full refusal with table not full")

  `AART_ASSERT_SAME(a_removed_only, out_tvalid && removed,
    status == aart_pkg::STS_DONE && !near, "removal flagged with other flags")

  `AART_ASSERT_SAME(a_occ_range, out_tvalid,
    (TABLE_DEPTH > 127) || ({25'd0, occ} <= depth_w), "occupancy beyond depth")

endmodule

bind aging_address_ring_table aart_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_aart_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/aging_address_ring_table_tb.sv =====
// Self-checking bench for aging_address_ring_table: directed and random traffic,
// shadow ring table predicting each result. Depends on aart_pkg and the RTL.
`timescale 1ns / 1ps

module aging_address_ring_table_tb;

  localparam int DEPTH = 64;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = DEPTH + 16;
  localparam logic [aart_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam logic [aart_pkg::ADDR_W-1:0] ADDR_ONES = '1;
  localparam logic [aart_pkg::TIME_W-1:0] TICK_ONES = '1;

  typedef struct packed {
    logic [aart_pkg::STATUS_W-1:0] status;
    logic                          near;
    logic                          removed;
    logic [aart_pkg::ADDR_W-1:0]   removed_addr;
    logic [aart_pkg::OCC_W-1:0]    occupancy;
  } table_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [aart_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [aart_pkg::CMD_W-1:0]      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [aart_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_we = 1'b0;
  logic                            cfg_index = 1'b0;
  logic [aart_pkg::TIME_W-1:0]     cfg_wdata = '0;

  // shadow of the table
  logic [aart_pkg::ADDR_W-1:0] ring_addr [DEPTH];
  logic [aart_pkg::TIME_W-1:0] ring_tick [DEPTH];
  int unsigned                 head_slot = 0;
  int unsigned                 tail_slot = 0;
  int unsigned                 fill = 0;
  logic [aart_pkg::TIME_W-1:0] age_ceiling = aart_pkg::MAX_AGE_RST;
  logic [aart_pkg::TIME_W-1:0] age_floor = aart_pkg::MIN_AGE_RST;

  table_result_t               pending_results [$];
  logic [aart_pkg::ADDR_W-1:0] addr_pool [16];
  logic [aart_pkg::TIME_W-1:0] tick_now = '0;
  int                          err_count = 0;
  int                          idle_cycles = 0;
  int                          stall_left = 0;
  int                          stall_roll;
  bit                          steady_flow = 1'b0;

  always #6 clk = ~clk;

  aging_address_ring_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic table_result_t compute_table_result(
      logic [aart_pkg::CMD_W-1:0] cmd,
      logic [aart_pkg::ADDR_W-1:0] addr,
      logic [aart_pkg::TIME_W-1:0] now);
    table_result_t res;
    int unsigned   slot;
    logic [aart_pkg::TIME_W-1:0] age;
    res = '0;
    case (cmd)
      aart_pkg::CMD_ADD: begin
        if (fill >= DEPTH) begin
          res.status = aart_pkg::STS_FULL;
        end else begin
          ring_addr[tail_slot] = addr;
          ring_tick[tail_slot] = now;
          tail_slot = (tail_slot + 1) % DEPTH;
          fill++;
        end
      end
      aart_pkg::CMD_QUERY: begin
        for (int k = 0; k < fill; k++) begin
          slot = (head_slot + k) % DEPTH;
          age = now - ring_tick[slot];
          if (ring_addr[slot] == addr && age > age_floor && age < age_ceiling)
            res.near = 1'b1;
        end
      end
      aart_pkg::CMD_EXPIRE: begin
        if (fill == 0) begin
          res.status = aart_pkg::STS_EMPTY;
        end else if (aart_pkg::TIME_W'(now - ring_tick[head_slot]) > age_ceiling) begin
          res.removed = 1'b1;
          res.removed_addr = ring_addr[head_slot];
          head_slot = (head_slot + 1) % DEPTH;
          fill--;
        end
      end
      default: ;
    endcase
    res.occupancy = aart_pkg::OCC_W'(fill);
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [aart_pkg::ADDR_W-1:0] random_address();
    return {16'($urandom), $urandom};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    err_count++;
  endtask

  // tvalid is lowered here only ahead of a gap (drain_results also lowers it), so back-to-back requests keep it high
  task automatic send_request(input logic [aart_pkg::CMD_W-1:0] cmd,
                              input logic [aart_pkg::ADDR_W-1:0] addr,
                              input logic [aart_pkg::TIME_W-1:0] now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {now, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(compute_table_result(cmd, addr, now));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input aart_pkg::reg_idx_t idx,
                           input logic [aart_pkg::TIME_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == aart_pkg::REG_MAX_AGE) age_ceiling = value;
    else age_floor = value;
    @(posedge clk);
  endtask

  task automatic run_traffic(input int count, input int add_pct);
    int roll;
    logic [aart_pkg::CMD_W-1:0]  cmd;
    logic [aart_pkg::ADDR_W-1:0] addr;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) tick_now += $urandom_range(0, 48);
      else if (roll < 92) tick_now += $urandom_range(0, 2500);
      else if (roll < 97) tick_now += $urandom;
      else tick_now = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < add_pct) cmd = aart_pkg::CMD_ADD;
      else if (roll < add_pct + (100 - add_pct) * 55 / 100) cmd = aart_pkg::CMD_QUERY;
      else if (roll < 97) cmd = aart_pkg::CMD_EXPIRE;
      else cmd = CMD_SPARE;
      // queries mostly look for something actually stored
      if (cmd == aart_pkg::CMD_QUERY && fill > 0 && $urandom_range(0, 99) < 60)
        addr = ring_addr[(head_slot + $urandom_range(0, fill - 1)) % DEPTH];
      else if ($urandom_range(0, 99) < 75)
        addr = addr_pool[$urandom_range(0, 15)];
      else
        addr = random_address();
      if (i == count / 2) drain_results();
      send_request(cmd, addr, tick_now);
    end
  endtask

  task automatic test_directed_cases();
    send_request(aart_pkg::CMD_EXPIRE, '0, '0);
    send_request(aart_pkg::CMD_QUERY, ADDR_ONES, '0);
    send_request(CMD_SPARE, ADDR_ONES, TICK_ONES);
    send_request(aart_pkg::CMD_ADD, '0, '0);
    send_request(aart_pkg::CMD_ADD, ADDR_ONES, TICK_ONES);
    send_request(aart_pkg::CMD_QUERY, ADDR_ONES, 32'd5);      // age wraps past zero
    send_request(aart_pkg::CMD_QUERY, '0, '0);                // age equals the floor
    send_request(aart_pkg::CMD_QUERY, '0, 32'd1199);
    send_request(aart_pkg::CMD_QUERY, '0, 32'd1200);          // age equals the ceiling
    send_request(aart_pkg::CMD_EXPIRE, '0, 32'd1200);         // not yet old enough
    send_request(aart_pkg::CMD_EXPIRE, '0, 32'd1201);
    send_request(aart_pkg::CMD_ADD, ADDR_ONES, 32'd10);
    send_request(aart_pkg::CMD_QUERY, ADDR_ONES, 32'd1205);   // only the newer copy is near
    send_request(aart_pkg::CMD_ADD, 48'h5555_5555_5555, 32'hAAAA_AAAA);
    send_request(aart_pkg::CMD_QUERY, 48'hAAAA_AAAA_AAAA, 32'h5555_5555);
    write_reg(aart_pkg::REG_MAX_AGE, '0);
    send_request(aart_pkg::CMD_QUERY, ADDR_ONES, 32'd11);
    send_request(aart_pkg::CMD_EXPIRE, ADDR_ONES, 32'd11);
    write_reg(aart_pkg::REG_MAX_AGE, aart_pkg::MAX_AGE_RST);
    write_reg(aart_pkg::REG_MIN_AGE, 32'd100);
    send_request(aart_pkg::CMD_QUERY, ADDR_ONES, 32'd110);
    send_request(aart_pkg::CMD_QUERY, ADDR_ONES, 32'd111);
    write_reg(aart_pkg::REG_MIN_AGE, aart_pkg::MIN_AGE_RST);
  endtask

  task automatic test_full_table();
    tick_now = 32'hFFFF_FF00;
    while (fill < DEPTH) begin
      tick_now += 1;
      send_request(aart_pkg::CMD_ADD, addr_pool[$urandom_range(0, 15)], tick_now);
    end
    send_request(aart_pkg::CMD_ADD, ADDR_ONES, tick_now);
    send_request(aart_pkg::CMD_ADD, random_address(), tick_now + 1);
    for (int i = 0; i < 6; i++)
      send_request(aart_pkg::CMD_QUERY,
                   ring_addr[(head_slot + $urandom_range(0, fill - 1)) % DEPTH],
                   tick_now + $urandom_range(0, 1300));
    tick_now += 2000;
    repeat (10) send_request(aart_pkg::CMD_EXPIRE, random_address(), tick_now);
    repeat (10) send_request(aart_pkg::CMD_ADD, random_address(), tick_now);
    // ring has wrapped; look at the freshest entries
    for (int i = 0; i < 6; i++)
      send_request(aart_pkg::CMD_QUERY, ring_addr[(tail_slot + DEPTH - 1 - i) % DEPTH],
                   tick_now + 3);
    tick_now += 5000;
    while (fill > 0) send_request(aart_pkg::CMD_EXPIRE, '0, tick_now);
    send_request(aart_pkg::CMD_EXPIRE, ADDR_ONES, tick_now);
  endtask

  task automatic test_age_windows();
    logic [aart_pkg::TIME_W-1:0] ceil_set [8];
    logic [aart_pkg::TIME_W-1:0] floor_set [8];
    int bias;
    ceil_set  = '{32'd0, TICK_ONES, TICK_ONES, 32'd3000, 32'd500, 32'd1, 32'd0, 32'd1200};
    floor_set = '{32'd0, 32'd0, TICK_ONES, 32'd600, 32'd499, 32'd0, 32'd0, 32'd0};
    ceil_set[6] = $urandom_range(2, 4000);
    floor_set[6] = $urandom_range(0, ceil_set[6] - 1);
    for (int p = 0; p < 8; p++) begin
      write_reg(aart_pkg::REG_MAX_AGE, ceil_set[p]);
      write_reg(aart_pkg::REG_MIN_AGE, floor_set[p]);
      steady_flow = (p == 3);
      bias = (p == 1 || p == 6) ? 65 : 40;
      if (p == 5) tick_now = 32'hFFFF_F000;
      run_traffic(120, bias);
    end
    steady_flow = 1'b0;
  endtask

  always @(posedge clk) begin
    if (steady_flow || stall_left == 0) begin
      out_tready <= 1'b1;
      if (!steady_flow) begin
        stall_roll = $urandom_range(0, 99);
        if (stall_roll < 12) stall_left = $urandom_range(1, 3);
        else if (stall_roll < 15) stall_left = $urandom_range(10, 40);
      end
    end else begin
      out_tready <= 1'b0;
      stall_left--;
    end
  end

  always @(posedge clk) begin
    table_result_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata, '0);
      end else begin
        due = pending_results.pop_front();
        if (out_tdata[1:0] !== due.status)
          report_mismatch("status", 64'(out_tdata[1:0]), 64'(due.status));
        if (out_tdata[2] !== due.near)
          report_mismatch("near", 64'(out_tdata[2]), 64'(due.near));
        if (out_tdata[3] !== due.removed)
          report_mismatch("removed", 64'(out_tdata[3]), 64'(due.removed));
        if (out_tdata[51:4] !== due.removed_addr)
          report_mismatch("removed_address", 64'(out_tdata[51:4]),
                          64'(due.removed_addr));
        if (out_tdata[58:52] !== due.occupancy)
          report_mismatch("occupancy", 64'(out_tdata[58:52]), 64'(due.occupancy));
      end
    end
  end

  // watchdog: nothing moving for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) addr_pool[i] = random_address();
    addr_pool[0] = '0;
    addr_pool[1] = ADDR_ONES;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_full_table();
    test_age_windows();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== aging_address_ring_table.f =====
+incdir+sv
sv/aart_pkg.sv
sv/aart_cell.sv
sv/aging_address_ring_table.sv
sv/aart_checker.sv
bench/aging_address_ring_table_tb.sv
